FILE: design/priority_schedule_wait_times_top_macros.svh
// assertion macros for the priority schedule block
// clk and rst_n are taken from the module that uses them
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_TOP_MACROS_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PSW_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psw assertion failed");

// next-cycle implication
`define PSW_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psw assertion failed");

`else

`define PSW_ASSERT_IMP(name, ante, cons)
`define PSW_ASSERT_NXT(name, ante, cons)

`endif

`endif

FILE: design/psw_pkg.sv
`timescale 1ns / 1ps

package psw_pkg;

    localparam int MAX_JOBS_DEF = 32;

    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int NUM_W   = 6;
    localparam int TIME_W  = 21;
    localparam int AVG_W   = 29;
    localparam int FRAC_W  = 8;

    // widths at the default job count
    localparam int CNT_W_DEF  = $clog2(MAX_JOBS_DEF + 1);
    localparam int SUM_W_DEF  = BURST_W + 2 * CNT_W_DEF;
    localparam int DIVD_W_DEF = SUM_W_DEF + FRAC_W;

    typedef struct packed {
        logic [BURST_W-1:0] burst_time;
        logic [PRIO_W-1:0]  priority_req;
        logic               last;
    } psw_in_t;

    typedef struct packed {
        logic [NUM_W-1:0]   job_number;
        logic [BURST_W-1:0] burst_echo;
        logic [PRIO_W-1:0]  priority_echo;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  turnaround_time;
        logic [AVG_W-1:0]   avg_wait_q8;
        logic [AVG_W-1:0]   avg_turnaround_q8;
        logic               final_res;
    } psw_out_t;

    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } psw_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_RI,
        S_SORT_LI,
        S_SORT_RJ,
        S_SORT_CJ,
        S_SORT_WI,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_DIV_WS,
        S_DIV_WW,
        S_DIV_TS,
        S_DIV_TW,
        S_FINAL
    } psw_state_t;

endpackage

FILE: design/priority_schedule_wait_times_top.sv
`timescale 1ns / 1ps
// channel   ports                   handshake
// job in    job (psw_in_t)          taken when start is high and busy is low
// result    result (psw_out_t)      valid for one cycle while result_strobe is high
//
// jobs load one per cycle while idle; busy stays low while jobs are collected
// after the last job, the held jobs are sorted by priority in the job memory,
// then both averages pass through the bit-serial divider
// results leave one at a time from the emit steps, the final one after both averages are divided
// reset clears the job count and the sequencer; the job memory is not cleared
// the receiver cannot stall, so results are never held back
`include "priority_schedule_wait_times_top_macros.svh"

module priority_schedule_wait_times_top
    import psw_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  psw_in_t  job,
    output logic     busy,
    output psw_out_t result,
    output logic     result_strobe
);

    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int WAIT_W = BURST_W + CNT_W;
    localparam int SUM_W  = BURST_W + 2 * CNT_W;
    localparam int DIVD_W = SUM_W + FRAC_W;

    // job memory, one read and one write port, read data registered
    psw_entry_t mem [MAX_JOBS];

    psw_state_t state_reg, state_next;

    logic [CNT_W-1:0]  job_count_reg, job_count_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    psw_entry_t        cur_reg, cur_next;
    psw_entry_t        rdata_reg;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [SUM_W-1:0]  sum_wait_reg, sum_wait_next;
    logic [SUM_W-1:0]  sum_tat_reg, sum_tat_next;
    logic [AVG_W-1:0]  avg_wait_reg, avg_wait_next;
    logic [AVG_W-1:0]  avg_tat_reg, avg_tat_next;
    psw_out_t          result_reg, result_next;
    logic              strobe_reg, strobe_next;

    // control decoded from the sequencer
    logic              accept;
    logic              store_ok;
    logic [CNT_W-1:0]  count_after;
    logic [CNT_W-1:0]  last_idx;
    logic [WAIT_W-1:0] tat_emit;
    logic [WAIT_W-1:0] tat_last;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    psw_entry_t        wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic              div_done;
    logic [DIVD_W-1:0] div_quotient;

    assign accept      = start && (state_reg == S_IDLE);
    assign store_ok    = (job_count_reg < CNT_W'(MAX_JOBS));
    assign count_after = job_count_reg + CNT_W'(store_ok);
    assign last_idx    = job_count_reg - 1'b1;
    assign tat_emit    = wait_reg + WAIT_W'(rdata_reg.burst);
    assign tat_last    = wait_reg + WAIT_W'(cur_reg.burst);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && job.last)
                begin
                    // a single job needs no sort
                    if (count_after > CNT_W'(1))
                        state_next = S_SORT_RI;
                    else
                        state_next = S_EMIT_RD;
                end
            end
            S_SORT_RI: state_next = S_SORT_LI;
            S_SORT_LI: state_next = S_SORT_RJ;
            S_SORT_RJ: state_next = S_SORT_CJ;
            S_SORT_CJ:
            begin
                if (j_reg == last_idx)
                    state_next = S_SORT_WI;
                else
                    state_next = S_SORT_RJ;
            end
            S_SORT_WI:
            begin
                if (CNT_W'(i_reg + 1'b1) == last_idx)
                    state_next = S_EMIT_RD;
                else
                    state_next = S_SORT_RI;
            end
            S_EMIT_RD: state_next = S_EMIT_OUT;
            S_EMIT_OUT:
            begin
                if (k_reg == last_idx)
                    state_next = S_DIV_WS;
                else
                    state_next = S_EMIT_RD;
            end
            S_DIV_WS: state_next = S_DIV_WW;
            S_DIV_WW:
            begin
                if (div_done)
                    state_next = S_DIV_TS;
            end
            S_DIV_TS: state_next = S_DIV_TW;
            S_DIV_TW:
            begin
                if (div_done)
                    state_next = S_FINAL;
            end
            S_FINAL:   state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        job_count_next = job_count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        wait_next      = wait_reg;
        sum_wait_next  = sum_wait_reg;
        sum_tat_next   = sum_tat_reg;
        avg_wait_next  = avg_wait_reg;
        avg_tat_next   = avg_tat_reg;
        result_next    = result_reg;
        strobe_next    = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = cur_reg;
        rd_addr        = '0;
        div_start      = 1'b0;
        div_dividend   = {sum_wait_reg, {FRAC_W{1'b0}}};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // a full store drops the job but still honors last
                    if (store_ok)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = job_count_reg[IDX_W-1:0];
                        wr_data.num   = NUM_W'(job_count_reg + 1'b1);
                        wr_data.burst = job.burst_time;
                        wr_data.prio  = job.priority_req;
                    end
                    job_count_next = count_after;
                    i_next         = '0;
                    k_next         = '0;
                    wait_next      = '0;
                    sum_wait_next  = '0;
                    sum_tat_next   = '0;
                end
            end
            S_SORT_RI:
            begin
                rd_addr = i_reg[IDX_W-1:0];
            end
            S_SORT_LI:
            begin
                // cur holds whatever currently sits at position i
                cur_next = rdata_reg;
                j_next   = i_reg + 1'b1;
            end
            S_SORT_RJ:
            begin
                rd_addr = j_reg[IDX_W-1:0];
            end
            S_SORT_CJ:
            begin
                // strictly smaller priority at j swaps with position i
                if (cur_reg.prio > rdata_reg.prio)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = j_reg[IDX_W-1:0];
                    wr_data  = cur_reg;
                    cur_next = rdata_reg;
                end
                j_next = j_reg + 1'b1;
            end
            S_SORT_WI:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg[IDX_W-1:0];
                wr_data = cur_reg;
                i_next  = i_reg + 1'b1;
            end
            S_EMIT_RD:
            begin
                rd_addr = k_reg[IDX_W-1:0];
            end
            S_EMIT_OUT:
            begin
                sum_wait_next = sum_wait_reg + SUM_W'(wait_reg);
                sum_tat_next  = sum_tat_reg + SUM_W'(tat_emit);
                if (k_reg == last_idx)
                begin
                    // final job waits for the averages
                    cur_next = rdata_reg;
                end
                else
                begin
                    result_next.job_number        = rdata_reg.num;
                    result_next.burst_echo        = rdata_reg.burst;
                    result_next.priority_echo     = rdata_reg.prio;
                    result_next.wait_time         = TIME_W'(wait_reg);
                    result_next.turnaround_time   = TIME_W'(tat_emit);
                    result_next.avg_wait_q8       = '0;
                    result_next.avg_turnaround_q8 = '0;
                    result_next.final_res         = 1'b0;
                    strobe_next                   = 1'b1;
                    wait_next                     = tat_emit;
                    k_next                        = k_reg + 1'b1;
                end
            end
            S_DIV_WS:
            begin
                div_start    = 1'b1;
                div_dividend = {sum_wait_reg, {FRAC_W{1'b0}}};
            end
            S_DIV_WW:
            begin
                if (div_done)
                    avg_wait_next = AVG_W'(div_quotient);
            end
            S_DIV_TS:
            begin
                div_start    = 1'b1;
                div_dividend = {sum_tat_reg, {FRAC_W{1'b0}}};
            end
            S_DIV_TW:
            begin
                if (div_done)
                    avg_tat_next = AVG_W'(div_quotient);
            end
            S_FINAL:
            begin
                result_next.job_number        = cur_reg.num;
                result_next.burst_echo        = cur_reg.burst;
                result_next.priority_echo     = cur_reg.prio;
                result_next.wait_time         = TIME_W'(wait_reg);
                result_next.turnaround_time   = TIME_W'(tat_last);
                result_next.avg_wait_q8       = avg_wait_reg;
                result_next.avg_turnaround_q8 = avg_tat_reg;
                result_next.final_res         = 1'b1;
                strobe_next                   = 1'b1;
                job_count_next                = '0;
            end
            default:
            begin
            end
        endcase
    end

    // shared divider for both averages, divisor is the job count
    psw_div #(
        .DIVIDEND_W (DIVD_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (job_count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_count_reg <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_count_reg <= job_count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            strobe_reg    <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        wait_reg     <= wait_next;
        sum_wait_reg <= sum_wait_next;
        sum_tat_reg  <= sum_tat_next;
        avg_wait_reg <= avg_wait_next;
        avg_tat_reg  <= avg_tat_next;
        result_reg   <= result_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    // a result only comes from the emit step or the final step
    `PSW_ASSERT_NXT(a_strobe_src, state_reg != S_EMIT_OUT && state_reg != S_FINAL, !result_strobe)
    // the final result leaves the store empty for the next set
    `PSW_ASSERT_IMP(a_final_clears, result_strobe && result.final_res, job_count_reg == '0)
    // the emit index never runs past the held jobs
    `PSW_ASSERT_IMP(a_emit_index, state_reg == S_EMIT_OUT, k_reg < job_count_reg)
    // a divider start is always followed by waiting for it
    `PSW_ASSERT_NXT(a_div_wait, div_start, state_reg == S_DIV_WW || state_reg == S_DIV_TW)

endmodule

FILE: design/psw_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module psw_div
    import psw_pkg::*;
#(
    parameter int DIVIDEND_W = DIVD_W_DEF,
    parameter int DIVISOR_W  = CNT_W_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb
    begin
        trial = {rem_reg, quot_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            step_next = STEP_W'(DIVIDEND_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quot_next = {quot_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
